[hdl/irla_pkg.sv]
package irla_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int DIST_W   = 8;
    localparam int TDATA_W  = 16;

    // linearization constants: floor(LIN_NUMERATOR / (sample - LIN_OFFSET)) - LIN_BIAS
    localparam int LIN_NUM_W = 13;
    localparam logic [LIN_NUM_W-1:0] LIN_NUMERATOR = 13'd6787;
    localparam logic [SAMPLE_W-1:0]  LIN_OFFSET    = 10'd3;
    localparam logic [DIST_W-1:0]    LIN_BIAS      = 8'd4;
    localparam logic [DIST_W-1:0]    DIST_MAX      = 8'd255;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DISTANCE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DISTANCE = 1'b1;

    // register reset values
    localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 8'd10;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 8'd80;

endpackage

[hdl/irla_sdiv.sv]
module irla_sdiv #(
    parameter int N_W = 13,
    parameter int D_W = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);

    // radix-4 restoring division: two quotient bits per cycle
    localparam int STEPS = (N_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] r_num, n_num;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    always_comb begin
        logic [D_W:0]     v_trial;
        logic [D_W-1:0]   v_rem;
        logic [PAD_W-1:0] v_num;
        logic             v_ge;
        v_rem = r_rem;
        v_num = r_num;
        for (int k = 0; k < 2; k++) begin
            v_trial = {v_rem, v_num[PAD_W-1]};
            v_ge    = (v_trial >= {1'b0, r_den});
            if (v_ge) begin
                v_trial = v_trial - {1'b0, r_den};
            end
            v_rem = v_trial[D_W-1:0];
            v_num = {v_num[PAD_W-2:0], v_ge};
        end
        n_rem = v_rem;
        n_num = v_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_num  <= PAD_W'(i_num);
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= CNT_W'(STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num[N_W-1:0];

endmodule

[hdl/ir_range_linearize_average_core.sv]
// sequence: the input transfer starts the radix-4 serial divider on the linearization,
//   the clamp state starts a second pass for the mean, and m_axis_tvalid is set as the
//   mean loads the output register; no new sample is taken until then, and a single
//   shared divider serves both the linearization and the mean
// reset: synchronous active-low; clears history, running sum, output valid,
//   and loads min_distance 10, max_distance 80
module ir_range_linearize_average_core #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream: tdata[9:0] sample, upper bits zero
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [irla_pkg::TDATA_W-1:0]    s_axis_tdata,
    // result stream: tdata[7:0] distance_cm, tdata[15:8] average_cm
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [irla_pkg::TDATA_W-1:0]    m_axis_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [irla_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [irla_pkg::DIST_W-1:0]     i_cfg_wdata
);

    localparam int DW      = irla_pkg::DIST_W;
    localparam int SUM_W   = DW + $clog2(HISTORY_DEPTH);
    // shared divider sized for both the linearization and the mean
    localparam int DIV_N_W = (SUM_W > irla_pkg::LIN_NUM_W) ? SUM_W : irla_pkg::LIN_NUM_W;
    localparam int DEP_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int DIV_D_W = (DEP_W > irla_pkg::SAMPLE_W) ? DEP_W : irla_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIN,
        S_CLAMP,
        S_AVG
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DW-1:0] r_min_dist;
    logic [DW-1:0] r_max_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= irla_pkg::MIN_DISTANCE_RST;
            r_max_dist <= irla_pkg::MAX_DISTANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                irla_pkg::CFG_MIN_DISTANCE: r_min_dist <= i_cfg_wdata;
                irla_pkg::CFG_MAX_DISTANCE: r_max_dist <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // datapath registers
    logic                r_sat;       // sample at or below the offset
    logic [DW-1:0]       r_raw;       // saturated linearized distance
    logic [DW-1:0]       r_dist;      // clamped distance of current item
    logic [SUM_W-1:0]    r_sum;       // running sum of the history
    logic [DW-1:0]       r_hist [HISTORY_DEPTH];
    logic                r_out_valid;
    logic [DW-1:0]       r_out_dist;
    logic [DW-1:0]       r_out_avg;

    logic [irla_pkg::SAMPLE_W-1:0] w_sample;
    logic                          w_in_xfer;
    logic                          w_out_xfer;
    logic                          w_out_free;

    assign w_sample   = s_axis_tdata[irla_pkg::SAMPLE_W-1:0];
    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // shared serial divider
    logic               w_div_start;
    logic [DIV_N_W-1:0] w_div_num;
    logic [DIV_D_W-1:0] w_div_den;
    logic               w_div_done;
    logic [DIV_N_W-1:0] w_div_quo;

    irla_sdiv #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // linearization of the quotient: subtract bias, saturate
    logic [DW-1:0] w_lin;
    always_comb begin
        if (w_div_quo < DIV_N_W'(irla_pkg::LIN_BIAS)) begin
            w_lin = '0;
        end else if ((w_div_quo - DIV_N_W'(irla_pkg::LIN_BIAS))
                     > DIV_N_W'(irla_pkg::DIST_MAX)) begin
            w_lin = irla_pkg::DIST_MAX;
        end else begin
            w_lin = DW'(w_div_quo - DIV_N_W'(irla_pkg::LIN_BIAS));
        end
    end

    // clamp window, lower bound tested first
    logic [DW-1:0] w_clamped;
    always_comb begin
        priority if (r_raw < r_min_dist) begin
            w_clamped = r_min_dist;
        end else if (r_raw > r_max_dist) begin
            w_clamped = r_max_dist;
        end else begin
            w_clamped = r_raw;
        end
    end

    // running sum: add newest, drop the entry that falls off the end
    logic [SUM_W-1:0] w_sum_next;
    assign w_sum_next = SUM_W'(r_sum + SUM_W'(w_clamped)
                              - SUM_W'(r_hist[HISTORY_DEPTH-1]));

    assign w_div_start = (r_state == S_CLAMP) || ((r_state == S_IDLE) && w_in_xfer);
    assign w_div_num   = (r_state == S_CLAMP) ? DIV_N_W'(w_sum_next)
                                              : DIV_N_W'(irla_pkg::LIN_NUMERATOR);
    assign w_div_den   = (r_state == S_CLAMP) ? DIV_D_W'(HISTORY_DEPTH)
                                              : DIV_D_W'(w_sample - irla_pkg::LIN_OFFSET);

    // history shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_sum <= '0;
        end else if (r_state == S_CLAMP) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= w_clamped;
            r_sum     <= w_sum_next;
        end
    end

    // mean ready and output register free: result loads this cycle
    logic w_avg_done;
    assign w_avg_done = (r_state == S_AVG) && w_div_done && w_out_free;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_xfer && !w_avg_done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_sat   <= (w_sample <= irla_pkg::LIN_OFFSET);
                        r_state <= S_LIN;
                    end
                end
                S_LIN: begin
                    if (w_div_done) begin
                        r_raw   <= r_sat ? irla_pkg::DIST_MAX : w_lin;
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_dist  <= w_clamped;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    // hold the mean until the output register is free
                    if (w_avg_done) begin
                        r_out_valid <= 1'b1;
                        r_out_dist  <= r_dist;
                        r_out_avg   <= w_div_quo[DW-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_avg, r_out_dist};

endmodule

[hdl/irla_chk.sv]
module irla_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [irla_pkg::TDATA_W-1:0]    m_axis_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // one sample at a time: no back-to-back input transfers
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // a new result appears only as the block returns to waiting for input
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while still busy");

    // reset leaves no result pending and the input open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("bad state after reset");

endmodule

bind ir_range_linearize_average_core irla_chk u_irla_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_W      = irla_pkg::SAMPLE_W;
    localparam int DIST_W        = irla_pkg::DIST_W;
    localparam int TDATA_W       = irla_pkg::TDATA_W;
    localparam int CFG_ADDR_W    = irla_pkg::CFG_ADDR_W;
    localparam int HISTORY_DEPTH = 8;
    // cycles with no transfer on either stream before the run is declared hung
    localparam int STALL_LIMIT   = 4000;
    // cycles to keep watching after the last expected result, latency plus margin
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 430;
    localparam int WINDOW_CHUNKS = 5;

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
        logic [DIST_W-1:0] avg;
    } t_range_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = irla_pkg::CFG_MIN_DISTANCE;
    logic [DIST_W-1:0]     i_cfg_wdata   = '0;

    // predicted block state: clamp window and distance history, newest in entry 0
    logic [DIST_W-1:0] win_min;
    logic [DIST_W-1:0] win_max;
    logic [DIST_W-1:0] dist_history [HISTORY_DEPTH];

    // results still owed by the block, oldest first
    t_range_result expected_q [$];
    t_range_result oldest_expected;

    int err_count     = 0;
    int stall_cycles  = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    always #4 i_clk = ~i_clk;

    ir_range_linearize_average_core #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [9:0] sample, upper bits zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] distance_cm, [15:8] average_cm
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // raw distance: floor(6787 / (sample - 3)) - 4, saturated to 255
    function automatic logic [DIST_W-1:0] linearize_sample(logic [SAMPLE_W-1:0] smp);
        int unsigned divisor;
        int unsigned quot;
        if (smp <= irla_pkg::LIN_OFFSET) begin
            return irla_pkg::DIST_MAX;
        end
        divisor = 32'(smp - irla_pkg::LIN_OFFSET);
        quot    = 32'(irla_pkg::LIN_NUMERATOR) / divisor;
        if (quot < 32'(irla_pkg::LIN_BIAS)) begin
            return '0;
        end
        quot = quot - 32'(irla_pkg::LIN_BIAS);
        return (quot > 32'(irla_pkg::DIST_MAX)) ? irla_pkg::DIST_MAX : DIST_W'(quot);
    endfunction

    // clamp, shift into the history and take the truncated mean
    function automatic t_range_result advance_history(logic [SAMPLE_W-1:0] smp);
        logic [DIST_W-1:0] d;
        int unsigned       total;
        t_range_result     r;
        d = linearize_sample(smp);
        // lower bound wins when the window is inverted
        if (d < win_min) begin
            d = win_min;
        end else if (d > win_max) begin
            d = win_max;
        end
        for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
            dist_history[k] = dist_history[k-1];
        end
        dist_history[0] = d;
        total = 0;
        foreach (dist_history[k]) begin
            total += 32'(dist_history[k]);
        end
        r.dist_cm = d;
        r.avg     = DIST_W'(total / HISTORY_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // one sample transfer, with an optional random gap in front of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(advance_history(smp));
    endtask

    // stop sending and wait until every owed result has been taken
    task automatic finish_stream();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
        end
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // both registers written back to back while the block is idle
    task automatic set_window(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
        finish_stream();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= irla_pkg::CFG_MIN_DISTANCE;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        win_min      = lo;
        i_cfg_addr  <= irla_pkg::CFG_MAX_DISTANCE;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        win_max      = hi;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        // mostly full range, with weight on the saturating and steep low end and on the top end
        if (pick < 60) begin
            return SAMPLE_W'($urandom_range(0, 1023));
        end else if (pick < 85) begin
            return SAMPLE_W'($urandom_range(0, 40));
        end else if (pick < 95) begin
            return SAMPLE_W'($urandom_range(900, 1023));
        end
        return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(1023) : SAMPLE_W'(0);
    endfunction

    // reset window, warm-up of the zero history, sample extremes and bit patterns
    task automatic test_warmup_and_extremes();
        logic [SAMPLE_W-1:0] pattern [22] = '{
            10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7,
            10'd1023, 10'd512, 10'h155, 10'h2aa, 10'd30, 10'd60, 10'd90,
            10'd100, 10'd150, 10'd250, 10'd400, 10'd700, 10'd29, 10'd31
        };
        foreach (pattern[k]) begin
            send_sample(pattern[k]);
        end
        finish_stream();
    endtask

    // window extremes: open, closed at either end, inverted
    task automatic test_clamp_window();
        logic [DIST_W-1:0]   win_lo [6] = '{8'd0,   8'd255, 8'd0, 8'd255, 8'd100, 8'd10};
        logic [DIST_W-1:0]   win_hi [6] = '{8'd255, 8'd0,   8'd0, 8'd255, 8'd40,  8'd80};
        logic [SAMPLE_W-1:0] probe  [9] = '{
            10'd0, 10'd3, 10'd4, 10'd5, 10'd10, 10'd30, 10'd100, 10'd400, 10'd1023
        };
        foreach (win_lo[w]) begin
            set_window(win_lo[w], win_hi[w]);
            foreach (probe[k]) begin
                send_sample(probe[k]);
            end
        end
        finish_stream();
    endtask

    // random samples under random windows, in three idling regimes
    task automatic test_random_traffic();
        int unsigned       kind;
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 9;  sink_idle_pct = 74; end
                1: begin src_idle_pct = 74; sink_idle_pct = 9;  end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int c = 0; c < WINDOW_CHUNKS; c++) begin
                kind = $urandom_range(0, 3);
                lo   = DIST_W'($urandom_range(0, 255));
                hi   = DIST_W'($urandom_range(0, 255));
                case (kind)
                    0: begin lo = 8'd0; hi = 8'd255; end
                    1: begin
                        if (lo > hi) begin
                            lo = lo ^ hi;
                            hi = lo ^ hi;
                            lo = lo ^ hi;
                        end
                    end
                    2: ;  // any order, inverted windows included
                    default: begin
                        lo = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                        hi = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                    end
                endcase
                set_window(lo, hi);
                for (int n = 0; n < RANDOM_ITEMS / WINDOW_CHUNKS; n++) begin
                    send_sample(random_sample());
                end
            end
        end
        finish_stream();
    endtask

    // result side: compare each transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing owed, tdata", int'(m_axis_tdata), 0);
            end else begin
                oldest_expected = expected_q.pop_front();
                if (m_axis_tdata[DIST_W-1:0] !== oldest_expected.dist_cm) begin
                    report_mismatch("distance_cm", int'(m_axis_tdata[DIST_W-1:0]),
                                    int'(oldest_expected.dist_cm));
                end
                if (m_axis_tdata[2*DIST_W-1:DIST_W] !== oldest_expected.avg) begin
                    report_mismatch("average_cm", int'(m_axis_tdata[2*DIST_W-1:DIST_W]),
                                    int'(oldest_expected.avg));
                end
            end
        end
        // receiver stall decided fresh every cycle
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // watchdog: any transfer on either stream restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[ir_range_linearize_average_core] ERROR");
            $finish;
        end
    end

    initial begin
        // predicted state after reset
        win_min = irla_pkg::MIN_DISTANCE_RST;
        win_max = irla_pkg::MAX_DISTANCE_RST;
        foreach (dist_history[k]) begin
            dist_history[k] = '0;
        end
        src_idle_pct  = 9;
        sink_idle_pct = 74;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_warmup_and_extremes();
        test_clamp_window();
        test_random_traffic();

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[ir_range_linearize_average_core] OK");
        end else begin
            $display("[ir_range_linearize_average_core] ERROR");
        end
        $finish;
    end

endmodule
